>>> rtl/aperture_table_lookup_or_insert_top_defines.svh
// assertion macros used by the aperture table search sequencer
`ifndef APERTURE_TABLE_LOOKUP_OR_INSERT_TOP_DEFINES_SVH
`define APERTURE_TABLE_LOOKUP_OR_INSERT_TOP_DEFINES_SVH

// property that must hold at every clock edge out of reset
`define ATL_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent must hold on the edge after the antecedent
`define ATL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/atl_pkg.sv
// types and constants of the aperture table
package atl_pkg;

    localparam int CODE_W          = 7;
    localparam int SIZE_W          = 24;
    localparam int SHAPE_W         = 3;
    localparam int DEF_TABLE_DEPTH = 64;

    localparam logic [CODE_W-1:0] CAP_RESET = CODE_W'(64);

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    typedef struct packed {
        logic               op;
        logic [SIZE_W-1:0]  size_x;
        logic [SIZE_W-1:0]  size_y;
        logic [SHAPE_W-1:0] shape;
    } in_item_t;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              hit;
        logic              table_full;
        logic              select_changed;
        logic [CODE_W-1:0] entries_used;
    } out_item_t;

    typedef struct packed {
        logic [SIZE_W-1:0]  width;
        logic [SIZE_W-1:0]  height;
        logic [SHAPE_W-1:0] shape;
    } entry_t;

endpackage

>>> rtl/atl_ram.sv
// generic single-write, single-read ram with registered read data
module atl_ram
    import atl_pkg::*;
#(
    parameter int WIDTH = $bits(entry_t),
    parameter int DEPTH = DEF_TABLE_DEPTH
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/atl_search.sv
// search sequencer: clears the table, or scans it one entry a cycle until a match, else inserts or fails
`include "aperture_table_lookup_or_insert_top_defines.svh"

module atl_search
    import atl_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  in_item_t          req_item,
    output logic              req_stall,
    input  logic [CODE_W-1:0] capacity,
    output logic              res_valid,
    output out_item_t         res,
    input  logic              res_ready
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int XW = (CW > CODE_W) ? CW : CODE_W;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SEARCH = 3'b010,
        ST_DONE   = 3'b100
    } state_t;

    state_t          state_reg,     state_next;
    entry_t          key_reg,       key_next;
    logic [CW-1:0]   used_reg,      used_next;
    logic [XW-1:0]   last_reg,      last_next;
    logic [CW-1:0]   rd_idx_reg,    rd_idx_next;
    logic            cmp_valid_reg, cmp_valid_next;
    logic [AW-1:0]   cmp_idx_reg,   cmp_idx_next;
    out_item_t       res_reg,       res_next;

    logic            accept;
    logic            wr_en;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    logic [$bits(entry_t)-1:0] rd_data;
    entry_t          rd_entry;
    logic            match;
    logic            at_end;
    logic            full;
    logic [XW-1:0]   used_x;
    logic [XW-1:0]   hit_code;
    logic [XW-1:0]   ins_code;

    atl_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (used_reg[AW-1:0]),
        .wr_data (key_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_entry  = rd_data;
    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;

    // read data is registered, so it belongs to the address of the cycle before
    assign match    = cmp_valid_reg && (rd_entry == key_reg);
    assign at_end   = (rd_idx_reg == used_reg);
    assign used_x   = XW'(used_reg);
    assign full     = (used_reg == CW'(TABLE_DEPTH)) || (used_x >= XW'(capacity));
    assign hit_code = XW'(cmp_idx_reg) + XW'(1);
    assign ins_code = used_x + XW'(1);

    always_comb
    begin
        state_next     = state_reg;
        key_next       = key_reg;
        used_next      = used_reg;
        last_next      = last_reg;
        rd_idx_next    = rd_idx_reg;
        cmp_valid_next = cmp_valid_reg;
        cmp_idx_next   = cmp_idx_reg;
        res_next       = res_reg;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = rd_idx_reg[AW-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req_item.op == OP_CLEAR)
                    begin
                        used_next  = '0;
                        last_next  = '0;
                        res_next   = '0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        key_next.width  = req_item.size_x;
                        key_next.height = req_item.size_y;
                        key_next.shape  = req_item.shape;
                        rd_idx_next     = '0;
                        cmp_valid_next  = 1'b0;
                        state_next      = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (match)
                begin
                    res_next.code           = hit_code[CODE_W-1:0];
                    res_next.hit            = 1'b1;
                    res_next.table_full     = 1'b0;
                    res_next.select_changed = (hit_code != last_reg);
                    res_next.entries_used   = used_x[CODE_W-1:0];
                    last_next               = hit_code;
                    state_next              = ST_DONE;
                end
                else if (at_end)
                begin
                    res_next.hit = 1'b0;
                    if (full)
                    begin
                        res_next.code           = '0;
                        res_next.table_full     = 1'b1;
                        res_next.select_changed = (last_reg != '0);
                        res_next.entries_used   = used_x[CODE_W-1:0];
                        last_next               = '0;
                    end
                    else
                    begin
                        wr_en                   = 1'b1;
                        used_next               = used_reg + CW'(1);
                        res_next.code           = ins_code[CODE_W-1:0];
                        res_next.table_full     = 1'b0;
                        res_next.select_changed = (ins_code != last_reg);
                        res_next.entries_used   = ins_code[CODE_W-1:0];
                        last_next               = ins_code;
                    end
                    state_next = ST_DONE;
                end
                else
                begin
                    rd_en          = 1'b1;
                    cmp_idx_next   = rd_idx_reg[AW-1:0];
                    cmp_valid_next = 1'b1;
                    rd_idx_next    = rd_idx_reg + CW'(1);
                end
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            last_reg      <= '0;
            rd_idx_reg    <= '0;
            cmp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            last_reg      <= last_next;
            rd_idx_reg    <= rd_idx_next;
            cmp_valid_reg <= cmp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        cmp_idx_reg <= cmp_idx_next;
        res_reg     <= res_next;
    end

    `ATL_ASSERT_ALWAYS(a_used_bound, used_reg <= CW'(TABLE_DEPTH), "used count beyond table depth")
    `ATL_ASSERT_ALWAYS(a_hit_not_full, !(res_valid && res.hit && res.table_full), "hit and full together")
    `ATL_ASSERT_NEXT(a_clear_empties, accept && (req_item.op == OP_CLEAR), (state_reg == ST_DONE) && (used_reg == '0) && (last_reg == '0), "clear did not empty the table")
    `ATL_ASSERT_NEXT(a_insert_grows, (state_reg == ST_SEARCH) && !match && at_end && !full, used_reg == CW'($past(used_reg) + CW'(1)), "insert did not grow the table")

endmodule

>>> rtl/aperture_table_lookup_or_insert_top.sv
// Aperture table look-up or insert. Each request item either clears the table or searches
// the entries in use, oldest first, and returns the number of the first entry matching
// width, height and shape, appending a new entry when none matches and capacity and table depth allow.
// The search reads one entry per cycle from a single-port-read table ram. The result is held
// in an output register, so the next item can be taken while it waits. Capacity is written
// through cfg_wr_en / cfg_wr_data; the user must write it only while the block is idle, as
// the block itself does not enforce this.
module aperture_table_lookup_or_insert_top
    import atl_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  in_item_t          req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output out_item_t         rsp,
    input  logic              cfg_wr_en,
    input  logic [CODE_W-1:0] cfg_wr_data
);

    logic [CODE_W-1:0] capacity_reg;
    logic              rsp_valid_reg;
    out_item_t         rsp_reg;
    logic              res_valid;
    logic              res_ready;
    out_item_t         res;

    atl_search #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_search (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_item  (req),
        .req_stall (req_stall),
        .capacity  (capacity_reg),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready)
    );

    // output slot frees up as soon as the held item is taken
    assign res_ready = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= CAP_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                capacity_reg <= cfg_wr_data;
            end
            if (res_ready)
            begin
                rsp_valid_reg <= res_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            rsp_reg <= res;
        end
    end

endmodule
